>>> design/skf_pkg.sv
package skf_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned MUL_STEPS = DATA_W / DIGIT_W;
  localparam int unsigned QUO_W     = DATA_W + FRAC_W;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic signed [DATA_W-1:0] Q_ONE      = 32'sd65536;
  localparam logic signed [DATA_W-1:0] VAR_RESET  = 32'sd65536000;
  localparam logic [DATA_W-2:0]        Q_RESET    = 31'd655;
  localparam logic [DATA_W-2:0]        R_RESET    = 31'd1638400;
  localparam logic signed [DATA_W-1:0] SAT_MAX    = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN    = 32'sh80000000;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSITION    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OBSERVE       = 8'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_MUL,
    PH_MFIN,
    PH_DIV,
    PH_DFIN,
    PH_DONE
  } phase_e;

  typedef enum logic [3:0] {
    ST_FX,
    ST_FP,
    ST_FPF,
    ST_ADDQ,
    ST_PH,
    ST_HP,
    ST_HPH,
    ST_ADDR,
    ST_DIV,
    ST_KH,
    ST_ONEK,
    ST_NEWP,
    ST_HX,
    ST_INNOV,
    ST_KI,
    ST_NEWX
  } step_e;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_DIV
  } op_e;

  typedef enum logic [2:0] {
    DST_X,
    DST_P,
    DST_T,
    DST_NUM,
    DST_DEN,
    DST_K
  } dst_e;

  function automatic step_e next_step(input step_e s);
    step_e n;
    unique case (s)
      ST_FX:    n = ST_FP;
      ST_FP:    n = ST_FPF;
      ST_FPF:   n = ST_ADDQ;
      ST_ADDQ:  n = ST_PH;
      ST_PH:    n = ST_HP;
      ST_HP:    n = ST_HPH;
      ST_HPH:   n = ST_ADDR;
      ST_ADDR:  n = ST_DIV;
      ST_DIV:   n = ST_KH;
      ST_KH:    n = ST_ONEK;
      ST_ONEK:  n = ST_NEWP;
      ST_NEWP:  n = ST_HX;
      ST_HX:    n = ST_INNOV;
      ST_INNOV: n = ST_KI;
      ST_KI:    n = ST_NEWX;
      default:  n = ST_FX;
    endcase
    return n;
  endfunction

  function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    r = v[DATA_W-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? SAT_MIN : SAT_MAX;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/scalar_kalman_filter_top.sv
// One-dimensional Kalman filter in signed Q16.16 fixed point.
// Input channel: in_valid_i, in_stall_o and sample_i carry one measurement per beat.
// Output channel: out_valid_o, out_stall_i, estimate_o and gain_o carry one result
// beat per measurement: the updated estimate and the gain of that step.
// Configuration channel: cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i write
// q (0), r (1), f (2) and h (3); other indexes are ignored. Write only while idle.
// Each measurement runs a sequence of ten products, five saturating sums and one
// quotient on one shared datapath: a product on the 4-bit-digit shift-add
// multiplier, the quotient on the bit-serial restoring divider, a sum directly
// from the combinational adder. The block takes the next measurement only after
// the result of the last one has moved into the output register.
// The input is stalled while a measurement is in work. A finished result waits in
// the output register while the receiver stalls; a new measurement may be taken
// meanwhile, and its result waits until the register is free.
// Reset clears the estimate to 0, sets the variance to 1000.0 and loads the
// configuration defaults: q about 0.01, r 25.0, f 1.0 and h 1.0.
module scalar_kalman_filter_top
  import skf_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [DATA_W-1:0]    sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [DATA_W-1:0]    estimate_o,
  output logic signed [DATA_W-1:0]    gain_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [DATA_W-1:0]           cfg_data_i
);

  phase_e phase_q, phase_d;
  step_e  step_q, step_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [DATA_W-2:0]        q_q, r_q;
  logic signed [DATA_W-1:0] f_q, h_q;
  logic signed [DATA_W-1:0] x_q, p_q;
  logic signed [DATA_W-1:0] z_q, t_q, num_q, den_q, k_q;
  logic signed [DATA_W-1:0] est_q, gain_q;
  logic                     out_valid_q;

  logic [DATA_W-1:0] ma_q, ma_d;
  logic [DATA_W-1:0] mb_q, mb_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] lo_q, lo_d;
  logic [QUO_W-1:0]  dn_q, dn_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic              neg_q, neg_d;
  logic              dz_q, dz_d;

  logic signed [DATA_W-1:0] opa, opb;
  op_e  op;
  dst_e dst;

  logic                     accept;
  logic                     op_done;
  logic                     wr_en;
  logic signed [DATA_W-1:0] res;
  logic                     out_load;

  logic [DATA_W+DIGIT_W-1:0] psum;
  logic [PROD_W-1:0]         mprod;
  logic signed [PROD_W-1:0]  mrnd;
  logic signed [DATA_W-1:0]  mres;
  logic [DATA_W:0]           dsh;
  logic [DATA_W:0]           ddiff;
  logic [QUO_W-1:0]          quo;
  logic signed [DATA_W-1:0]  dres;
  logic signed [DATA_W:0]    asum;
  logic signed [DATA_W-1:0]  ares;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (phase_q != PH_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign estimate_o  = est_q;
  assign gain_o      = gain_q;

  always_comb begin
    opa = t_q;
    opb = t_q;
    op  = OP_MUL;
    dst = DST_T;
    unique case (step_q)
      ST_FX:    begin opa = f_q;   opb = x_q;   op = OP_MUL; dst = DST_X;   end
      ST_FP:    begin opa = f_q;   opb = p_q;   op = OP_MUL; dst = DST_T;   end
      ST_FPF:   begin opa = t_q;   opb = f_q;   op = OP_MUL; dst = DST_T;   end
      ST_ADDQ:  begin opa = t_q;   opb = $signed({1'b0, q_q}); op = OP_ADD; dst = DST_P; end
      ST_PH:    begin opa = p_q;   opb = h_q;   op = OP_MUL; dst = DST_NUM; end
      ST_HP:    begin opa = h_q;   opb = p_q;   op = OP_MUL; dst = DST_T;   end
      ST_HPH:   begin opa = t_q;   opb = h_q;   op = OP_MUL; dst = DST_T;   end
      ST_ADDR:  begin opa = t_q;   opb = $signed({1'b0, r_q}); op = OP_ADD; dst = DST_DEN; end
      ST_DIV:   begin opa = num_q; opb = den_q; op = OP_DIV; dst = DST_K;   end
      ST_KH:    begin opa = k_q;   opb = h_q;   op = OP_MUL; dst = DST_T;   end
      ST_ONEK:  begin opa = Q_ONE; opb = t_q;   op = OP_SUB; dst = DST_T;   end
      ST_NEWP:  begin opa = t_q;   opb = p_q;   op = OP_MUL; dst = DST_P;   end
      ST_HX:    begin opa = h_q;   opb = x_q;   op = OP_MUL; dst = DST_T;   end
      ST_INNOV: begin opa = z_q;   opb = t_q;   op = OP_SUB; dst = DST_T;   end
      ST_KI:    begin opa = k_q;   opb = t_q;   op = OP_MUL; dst = DST_T;   end
      ST_NEWX:  begin opa = x_q;   opb = t_q;   op = OP_ADD; dst = DST_X;   end
      default:  begin opa = t_q;   opb = t_q;   op = OP_MUL; dst = DST_T;   end
    endcase
  end

  always_comb begin
    if (op == OP_SUB) begin
      asum = {opa[DATA_W-1], opa} - {opb[DATA_W-1], opb};
    end else begin
      asum = {opa[DATA_W-1], opa} + {opb[DATA_W-1], opb};
    end
    ares = sat33(asum);
  end

  always_comb begin
    psum  = {{DIGIT_W{1'b0}}, acc_q} + ma_q * mb_q[DIGIT_W-1:0];
    mprod = {acc_q, lo_q};
    if (neg_q) begin
      mrnd = $signed(PROD_W'(1) << (FRAC_W - 1)) - $signed(mprod);
    end else begin
      mrnd = $signed(mprod) + $signed(PROD_W'(1) << (FRAC_W - 1));
    end
    if (mrnd[PROD_W-1:DATA_W+FRAC_W-1] == '0 || mrnd[PROD_W-1:DATA_W+FRAC_W-1] == '1) begin
      mres = mrnd[DATA_W+FRAC_W-1:FRAC_W];
    end else begin
      mres = mrnd[PROD_W-1] ? SAT_MIN : SAT_MAX;
    end
  end

  always_comb begin
    dsh   = {rem_q, dn_q[QUO_W-1]};
    ddiff = dsh - {1'b0, ma_q};
    quo   = dn_q;
    if (dz_q) begin
      dres = '0;
    end else if (quo[QUO_W-1:DATA_W-1] != '0) begin
      dres = neg_q ? SAT_MIN : SAT_MAX;
    end else if (neg_q) begin
      dres = -$signed(quo[DATA_W-1:0]);
    end else begin
      dres = $signed(quo[DATA_W-1:0]);
    end
  end

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (accept) begin
          phase_d = PH_START;
          step_d  = ST_FX;
        end
      end
      PH_START: begin
        cnt_d = '0;
        unique case (op)
          OP_MUL:  phase_d = PH_MUL;
          OP_DIV:  phase_d = PH_DIV;
          default: phase_d = PH_START;
        endcase
      end
      PH_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
          phase_d = PH_MFIN;
        end
      end
      PH_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          phase_d = PH_DFIN;
        end
      end
      PH_MFIN, PH_DFIN: begin
        phase_d = PH_START;
      end
      PH_DONE: begin
        if (out_load) begin
          phase_d = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
    if (op_done) begin
      if (step_q == ST_NEWX) begin
        phase_d = PH_DONE;
      end else begin
        phase_d = PH_START;
        step_d  = next_step(step_q);
      end
    end
  end

  always_comb begin
    op_done  = 1'b0;
    wr_en    = 1'b0;
    res      = ares;
    out_load = 1'b0;
    ma_d     = ma_q;
    mb_d     = mb_q;
    acc_d    = acc_q;
    lo_d     = lo_q;
    dn_d     = dn_q;
    rem_d    = rem_q;
    neg_d    = neg_q;
    dz_d     = dz_q;
    unique case (phase_q)
      PH_START: begin
        ma_d  = mag32(opa);
        acc_d = '0;
        lo_d  = '0;
        rem_d = '0;
        neg_d = opa[DATA_W-1] ^ opb[DATA_W-1];
        if (op == OP_DIV) begin
          ma_d = mag32(opb);
          dn_d = {mag32(opa), {FRAC_W{1'b0}}};
          dz_d = (opb == '0);
        end else begin
          mb_d = mag32(opb);
        end
        if (op == OP_ADD || op == OP_SUB) begin
          wr_en   = 1'b1;
          res     = ares;
          op_done = 1'b1;
        end
      end
      PH_MUL: begin
        acc_d = psum[DATA_W+DIGIT_W-1:DIGIT_W];
        lo_d  = {psum[DIGIT_W-1:0], lo_q[DATA_W-1:DIGIT_W]};
        mb_d  = mb_q >> DIGIT_W;
      end
      PH_DIV: begin
        if (!ddiff[DATA_W]) begin
          rem_d = ddiff[DATA_W-1:0];
          dn_d  = {dn_q[QUO_W-2:0], 1'b1};
        end else begin
          rem_d = dsh[DATA_W-1:0];
          dn_d  = {dn_q[QUO_W-2:0], 1'b0};
        end
      end
      PH_MFIN: begin
        wr_en   = 1'b1;
        res     = mres;
        op_done = 1'b1;
      end
      PH_DFIN: begin
        wr_en   = 1'b1;
        res     = dres;
        op_done = 1'b1;
      end
      PH_DONE: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        op_done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      step_q      <= ST_FX;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      q_q         <= Q_RESET;
      r_q         <= R_RESET;
      f_q         <= Q_ONE;
      h_q         <= Q_ONE;
      x_q         <= '0;
      p_q         <= VAR_RESET;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        priority case (cfg_index_i)
          REG_PROCESS_NOISE: q_q <= cfg_data_i[DATA_W-2:0];
          REG_MEASURE_NOISE: r_q <= cfg_data_i[DATA_W-2:0];
          REG_TRANSITION:    f_q <= $signed(cfg_data_i);
          REG_OBSERVE:       h_q <= $signed(cfg_data_i);
          default:           ;
        endcase
      end
      if (wr_en && dst == DST_X) begin
        x_q <= res;
      end
      if (wr_en && dst == DST_P) begin
        p_q <= res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    acc_q <= acc_d;
    lo_q  <= lo_d;
    dn_q  <= dn_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    dz_q  <= dz_d;
    if (accept) begin
      z_q <= sample_i;
    end
    if (wr_en) begin
      unique case (dst)
        DST_T:   t_q   <= res;
        DST_NUM: num_q <= res;
        DST_DEN: den_q <= res;
        DST_K:   k_q   <= res;
        default: ;
      endcase
    end
    if (out_load) begin
      est_q  <= x_q;
      gain_q <= k_q;
    end
  end

endmodule

>>> test/tb_scalar_kalman_filter_top.sv
`timescale 1ns / 100ps

module tb_scalar_kalman_filter_top;
  import skf_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned PHASE_ITEMS = 105;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_OBSERVE + 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] estimate;
    logic signed [DATA_W-1:0] gain;
  } filter_out_t;

  class kalman_scoreboard;
    logic signed [DATA_W-1:0] q, r, f, h, x, p;
    filter_out_t expected_q[$];
    int errors;
    int checked;

    function void reset_state();
      q = {1'b0, Q_RESET};
      r = {1'b0, R_RESET};
      f = Q_ONE;
      h = Q_ONE;
      x = '0;
      p = VAR_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] d);
      case (idx)
        REG_PROCESS_NOISE: q = {1'b0, d[DATA_W-2:0]};
        REG_MEASURE_NOISE: r = {1'b0, d[DATA_W-2:0]};
        REG_TRANSITION:    f = d;
        REG_OBSERVE:       h = d;
        default: ;
      endcase
    endfunction

    function logic signed [DATA_W-1:0] clamp(longint v);
      if (v > longint'(SAT_MAX)) return SAT_MAX;
      if (v < longint'(SAT_MIN)) return SAT_MIN;
      return v[DATA_W-1:0];
    endfunction

    function logic signed [DATA_W-1:0] fmul(logic signed [DATA_W-1:0] a,
                                            logic signed [DATA_W-1:0] b);
      longint t;
      t = longint'(a) * longint'(b) + 64'sd32768;
      return clamp(t >>> FRAC_W);
    endfunction

    function logic signed [DATA_W-1:0] fadd(logic signed [DATA_W-1:0] a,
                                            logic signed [DATA_W-1:0] b);
      return clamp(longint'(a) + longint'(b));
    endfunction

    function logic signed [DATA_W-1:0] fsub(logic signed [DATA_W-1:0] a,
                                            logic signed [DATA_W-1:0] b);
      return clamp(longint'(a) - longint'(b));
    endfunction

    function logic signed [DATA_W-1:0] fdiv(logic signed [DATA_W-1:0] num,
                                            logic signed [DATA_W-1:0] den);
      if (den == 0) return '0;
      return clamp((longint'(num) * 64'sd65536) / longint'(den));
    endfunction

    function void note_sample(logic signed [DATA_W-1:0] z);
      logic signed [DATA_W-1:0] xp, pp, num, den, k;
      filter_out_t e;
      xp = fmul(f, x);
      pp = fadd(fmul(fmul(f, p), f), q);
      num = fmul(pp, h);
      den = fadd(fmul(fmul(h, pp), h), r);
      k = fdiv(num, den);
      p = fmul(fsub(Q_ONE, fmul(k, h)), pp);
      x = fadd(xp, fmul(k, fsub(z, fmul(h, xp))));
      e.estimate = x;
      e.gain = k;
      expected_q.push_back(e);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] est,
                               logic signed [DATA_W-1:0] gain);
      filter_out_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: estimate %0d gain %0d", est, gain);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (est !== e.estimate) begin
        $error("estimate: expected %0d actual %0d", e.estimate, est);
        errors++;
      end
      if (gain !== e.gain) begin
        $error("gain: expected %0d actual %0d", e.gain, gain);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [DATA_W-1:0] sample_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] estimate_o;
  logic signed [DATA_W-1:0] gain_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0] cfg_data_i = '0;

  kalman_scoreboard sb;
  bit no_idle = 1'b0;
  int unsigned quiet_cycles = 0;
  int samples_sent = 0;
  int cfg_writes = 0;

  scalar_kalman_filter_top dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(estimate_o, gain_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : receiver
    int n;
    @(posedge rst_ni);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 15);
      if (n > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send_sample(logic signed [DATA_W-1:0] s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_sample(s);
    samples_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, d);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_filter(logic [DATA_W-1:0] nq, logic [DATA_W-1:0] nr,
                            logic [DATA_W-1:0] nf, logic [DATA_W-1:0] nh);
    write_reg(REG_PROCESS_NOISE, nq);
    write_reg(REG_MEASURE_NOISE, nr);
    write_reg(REG_TRANSITION, nf);
    write_reg(REG_OBSERVE, nh);
  endtask

  task automatic random_phase(int count);
    logic signed [DATA_W-1:0] level;
    logic signed [DATA_W-1:0] s;
    level = $signed($urandom_range(0, 32'h7fff_ffff)) >>> $urandom_range(4, 12);
    if ($urandom_range(0, 1)) level = -level;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        s = level + $signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8;
      end else begin
        s = $urandom;
      end
      send_sample(s);
    end
  endtask

  initial begin
    logic signed [DATA_W-1:0] edge_vals [10];
    sb = new();
    sb.reset_state();
    edge_vals = '{32'sh7fff_ffff, 32'sh8000_0000, 0, 1, -1, Q_ONE, -Q_ONE,
                  32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0000_8000};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    no_idle = 1'b0;
    foreach (edge_vals[i]) send_sample(edge_vals[i]);
    drain();
    write_reg(REG_UNUSED, 32'hffff_ffff);
    write_reg(8'hff, 32'h1234_5678);
    set_filter(32'hffff_ffff, 32'h8000_0000, 32'sh8000_0000, 32'sh7fff_ffff);
    foreach (edge_vals[i]) send_sample(edge_vals[i]);
    drain();
    set_filter(32'h0, 32'h0, Q_ONE, 32'h0);
    for (int i = 0; i < 4; i++) send_sample(edge_vals[i]);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_filter({1'b0, Q_RESET}, {1'b0, R_RESET}, Q_ONE, Q_ONE);
        1: set_filter(32'h7fff_ffff, 32'h7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
        2: set_filter(32'h0, 32'h0, 32'h0, Q_ONE);
        3: set_filter($urandom, $urandom, $urandom, $urandom);
        default: set_filter($urandom_range(0, 65536), $urandom_range(1, 65536 * 100),
                            Q_ONE + $urandom_range(0, 8192) - 4096,
                            Q_ONE + $urandom_range(0, 32768) - 16384);
      endcase
      no_idle = (ph % 3 == 1);
      random_phase(PHASE_ITEMS);
      drain();
    end

    $display("Covered %0d samples with %0d register writes over saturating,", samples_sent,
             cfg_writes);
    $display("zero-denominator and nominal filter settings; %0d results checked.",
             sb.checked);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> scalar_kalman_filter_top.f
design/skf_pkg.sv
design/scalar_kalman_filter_top.sv
test/tb_scalar_kalman_filter_top.sv
